### sv/nddp_pkg.sv
// ============================================================================
// nddp_pkg
// Shared widths, case codes and sideband types for the disk pair distance
// pipeline.
// ============================================================================
`default_nettype none

package nddp_pkg;

   // input field widths
   localparam int COORD_W       = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DIST_FRAC     = 15;

   // squared distance and square root
   localparam int SQ_W       = 33;              // dx*dx + dy*dy
   localparam int RAD_W      = 34;              // SQ_W padded to whole digit pairs
   localparam int ROOT_W     = 32;              // floor(sqrt(S) * 2^DIST_FRAC)
   localparam int SQ_STEPS   = ROOT_W;
   localparam int SQ_PER_STG = 2;
   localparam int SQ_STAGES  = SQ_STEPS / SQ_PER_STG;

   // division
   localparam int NUM_W      = 34;
   localparam int DEN_W      = 33;
   localparam int DIV_PER_STG = 2;

   localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      CASE_CONTAINED   = 2'd0,
      CASE_OVERLAPPING = 2'd1,
      CASE_DISJOINT    = 2'd2
   } case_type;

   // per-item control carried down the pipeline
   typedef struct packed {
      case_type             kind;
      logic                 zdiv;
      logic [COORD_W-1:0]   diff;
      logic [COORD_W:0]     sum;
      logic [COORD_W-1:0]   r2;
   } side_type;

endpackage

`default_nettype wire

### sv/normalized_disk_pair_distance.sv
// ============================================================================
// normalized_disk_pair_distance
// Normalized distance of two disks: orders radii, takes the centre distance
// by a pipelined square root and divides through a pipelined long divider.
// ============================================================================
// Usage:
//  - Input beat: req_* fields with start; accepted when start is high and
//    busy is low. busy is always low: one pair is taken every cycle.
//  - Result beat: rsp_* fields marked by rsp_valid for exactly one cycle.
//    The receiver cannot stall, and the pipeline never needs it to.
//  - Depth is set by the square root (two root bits per stage, 16 stages)
//    and the long divider (two quotient bits per stage).
//  - Throughput: one pair per cycle.
//  - csr_we / csr_wdata write max_radius (value 0 acts as 1); write only
//    while no pair is in flight.
//  - Reset clears all valid bits and sets max_radius to 65535.
// ============================================================================
`default_nettype none

module normalized_disk_pair_distance
   import nddp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic [COORD_W-1:0]  req_first_center_x,
   input  wire logic [COORD_W-1:0]  req_first_center_y,
   input  wire logic [COORD_W-1:0]  req_first_radius,
   input  wire logic [COORD_W-1:0]  req_second_center_x,
   input  wire logic [COORD_W-1:0]  req_second_center_y,
   input  wire logic [COORD_W-1:0]  req_second_radius,
   input  wire logic                csr_we,
   input  wire logic [COORD_W-1:0]  csr_wdata,
   output      logic                rsp_valid,
   output      logic signed [31:0]  rsp_pair_distance,
   output      logic [1:0]          rsp_case_taken,
   output      logic                rsp_saturated,
   output      logic                rsp_zero_divisor
);

   localparam int XW         = NUM_W + FRAC_BITS + 1;
   localparam int DIV_STAGES = (XW + DIV_PER_STG - 1) / DIV_PER_STG;

   assign busy = 1'b0;

   // configuration register
   logic [COORD_W-1:0] max_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '1;
      end else if (csr_we) begin
         max_ff <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: order radii, absolute coordinate differences
   // ---------------------------------------------------------------------
   logic               s1_vld_ff;
   logic [COORD_W-1:0] s1_dx_ff, s1_dy_ff, s1_r1_ff, s1_r2_ff;
   logic               in_take;

   assign in_take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_take;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff <= (req_first_center_x > req_second_center_x) ?
                  req_first_center_x - req_second_center_x :
                  req_second_center_x - req_first_center_x;
      s1_dy_ff <= (req_first_center_y > req_second_center_y) ?
                  req_first_center_y - req_second_center_y :
                  req_second_center_y - req_first_center_y;
      s1_r1_ff <= (req_first_radius > req_second_radius) ?
                  req_first_radius : req_second_radius;
      s1_r2_ff <= (req_first_radius > req_second_radius) ?
                  req_second_radius : req_first_radius;
   end

   // ---------------------------------------------------------------------
   // stage 2: squares
   // ---------------------------------------------------------------------
   logic                 s2_vld_ff;
   logic [2*COORD_W-1:0] s2_dx2_ff, s2_dy2_ff, s2_diff2_ff;
   logic [2*COORD_W+1:0] s2_sum2_ff;
   logic [COORD_W-1:0]   s2_diff_ff, s2_r2_ff;
   logic [COORD_W:0]     s2_sum_ff;
   logic [COORD_W-1:0]   s2_diff_in;
   logic [COORD_W:0]     s2_sum_in;

   assign s2_diff_in = s1_r1_ff - s1_r2_ff;
   assign s2_sum_in  = {1'b0, s1_r1_ff} + {1'b0, s1_r2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_dx2_ff   <= s1_dx_ff * s1_dx_ff;
      s2_dy2_ff   <= s1_dy_ff * s1_dy_ff;
      s2_diff2_ff <= s2_diff_in * s2_diff_in;
      s2_sum2_ff  <= s2_sum_in * s2_sum_in;
      s2_diff_ff  <= s2_diff_in;
      s2_sum_ff   <= s2_sum_in;
      s2_r2_ff    <= s1_r2_ff;
   end

   // ---------------------------------------------------------------------
   // stage 3: squared distance and case choice (feeds square root slot 0)
   // ---------------------------------------------------------------------
   logic              sq_vld_ff  [SQ_STAGES+1];
   side_type          sq_side_ff [SQ_STAGES+1];
   logic [RAD_W-1:0]  sq_rad_ff  [SQ_STAGES+1];
   logic [RAD_W-1:0]  sq_rem_ff  [SQ_STAGES+1];
   logic [ROOT_W-1:0] sq_root_ff [SQ_STAGES+1];
   logic [SQ_W-1:0]   s3_s;
   side_type          s3_side;

   assign s3_s = {1'b0, s2_dx2_ff} + {1'b0, s2_dy2_ff};

   always_comb begin
      s3_side.diff = s2_diff_ff;
      s3_side.sum  = s2_sum_ff;
      s3_side.r2   = s2_r2_ff;
      s3_side.zdiv = 1'b0;
      if ({1'b0, s3_s} <= {2'b00, s2_diff2_ff}) begin
         s3_side.kind = CASE_CONTAINED;
         s3_side.zdiv = (s2_diff_ff == '0);
      end else if ({1'b0, s3_s} <= s2_sum2_ff) begin
         s3_side.kind = CASE_OVERLAPPING;
      end else begin
         s3_side.kind = CASE_DISJOINT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_side_ff[0] <= s3_side;
      sq_rad_ff[0]  <= {1'b0, s3_s};
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
   end

   // ---------------------------------------------------------------------
   // square root: two result bits per stage; low radicand digits are zero
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      logic [RAD_W-1:0]  rad_in, rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W+1:0]  t, trial;

      always_comb begin
         rad_in  = sq_rad_ff[g];
         rem_in  = sq_rem_ff[g];
         root_in = sq_root_ff[g];
         t       = '0;
         trial   = '0;
         for (int k = 0; k < SQ_PER_STG; k++) begin
            t     = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (t >= trial) begin
               rem_in  = RAD_W'(t - trial);
               root_in = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = t[RAD_W-1:0];
               root_in = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_in = {rad_in[RAD_W-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[g+1] <= 1'b0;
         end else begin
            sq_vld_ff[g+1] <= sq_vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         sq_side_ff[g+1] <= sq_side_ff[g];
         sq_rad_ff[g+1]  <= rad_in;
         sq_rem_ff[g+1]  <= rem_in;
         sq_root_ff[g+1] <= root_in;
      end
   end

   // ---------------------------------------------------------------------
   // prep: numerator with rounding term, denominator (divider slot 0)
   // ---------------------------------------------------------------------
   logic             dv_vld_ff  [DIV_STAGES+1];
   side_type         dv_side_ff [DIV_STAGES+1];
   logic [XW-1:0]    dv_x_ff    [DIV_STAGES+1];
   logic [DEN_W-1:0] dv_rem_ff  [DIV_STAGES+1];
   logic [DEN_W-1:0] dv_den_ff  [DIV_STAGES+1];
   side_type         pp_side;
   logic [NUM_W-1:0] pp_dq, pp_diffq, pp_sumq, pp_r2q, pp_mq, pp_num;
   logic [XW-1:0]    pp_x;
   logic [DEN_W-1:0] pp_den;

   assign pp_side  = sq_side_ff[SQ_STAGES];
   assign pp_dq    = NUM_W'(sq_root_ff[SQ_STAGES]);
   assign pp_diffq = NUM_W'(pp_side.diff) << DIST_FRAC;
   assign pp_sumq  = NUM_W'(pp_side.sum) << DIST_FRAC;
   assign pp_r2q   = NUM_W'(pp_side.r2) << DIST_FRAC;
   assign pp_mq    = NUM_W'((max_ff == '0) ? COORD_W'(1) : max_ff) << DIST_FRAC;

   always_comb begin
      pp_num = '0;
      pp_x   = '0;
      pp_den = DEN_W'(1);
      unique case (pp_side.kind)
         CASE_CONTAINED: begin
            pp_num = (pp_diffq << 1) + pp_diffq + pp_dq;
            pp_den = DEN_W'(pp_diffq << 2);
            pp_x   = (XW'(pp_num) << FRAC_BITS) + XW'(pp_diffq << 1);
            if (pp_side.zdiv) begin
               pp_den = DEN_W'(1);
               pp_x   = '0;
            end
         end
         CASE_OVERLAPPING: begin
            pp_num = pp_dq - pp_diffq + pp_r2q;
            pp_den = DEN_W'(pp_r2q);
            pp_x   = (XW'(pp_num) << FRAC_BITS) + XW'(pp_r2q >> 1);
         end
         CASE_DISJOINT: begin
            pp_num = pp_dq - pp_sumq;
            pp_den = DEN_W'(pp_mq);
            pp_x   = (XW'(pp_num) << (FRAC_BITS + 1)) + XW'(pp_mq >> 1);
         end
         default: begin
            pp_num = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[SQ_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      dv_side_ff[0] <= pp_side;
      dv_x_ff[0]    <= pp_x;
      dv_rem_ff[0]  <= '0;
      dv_den_ff[0]  <= pp_den;
   end

   // ---------------------------------------------------------------------
   // long division: two quotient bits per stage, quotient fills x from LSB
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_dv
      logic [XW-1:0]    x_in;
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W:0]   t;

      always_comb begin
         x_in   = dv_x_ff[g];
         rem_in = dv_rem_ff[g];
         t      = '0;
         for (int k = 0; k < DIV_PER_STG; k++) begin
            if (g * DIV_PER_STG + k < XW) begin
               t = {rem_in, x_in[XW-1]};
               if (t >= {1'b0, dv_den_ff[g]}) begin
                  rem_in = DEN_W'(t - {1'b0, dv_den_ff[g]});
                  x_in   = {x_in[XW-2:0], 1'b1};
               end else begin
                  rem_in = t[DEN_W-1:0];
                  x_in   = {x_in[XW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[g+1] <= 1'b0;
         end else begin
            dv_vld_ff[g+1] <= dv_vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         dv_side_ff[g+1] <= dv_side_ff[g];
         dv_x_ff[g+1]    <= x_in;
         dv_rem_ff[g+1]  <= rem_in;
         dv_den_ff[g+1]  <= dv_den_ff[g];
      end
   end

   // ---------------------------------------------------------------------
   // output: disjoint offset and saturation, registered result beat
   // ---------------------------------------------------------------------
   side_type       ot_side;
   logic [XW-1:0]  ot_q;
   logic [XW:0]    ot_far;
   logic [31:0]    ot_value;
   logic           ot_sat;

   assign ot_side = dv_side_ff[DIV_STAGES];
   assign ot_q    = dv_x_ff[DIV_STAGES];
   assign ot_far  = ((XW+1)'(3) << FRAC_BITS) + {1'b0, ot_q};

   always_comb begin
      ot_sat   = 1'b0;
      ot_value = 32'(ot_q);
      unique case (ot_side.kind)
         CASE_CONTAINED: begin
            if (ot_side.zdiv) begin
               ot_value = '0;
            end
         end
         CASE_OVERLAPPING: begin
            ot_value = 32'(ot_q);
         end
         CASE_DISJOINT: begin
            if (ot_far > (XW+1)'(VALUE_MAX)) begin
               ot_sat   = 1'b1;
               ot_value = VALUE_MAX;
            end else begin
               ot_value = 32'(ot_far);
            end
         end
         default: begin
            ot_value = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dv_vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_pair_distance <= ot_value;
      rsp_case_taken    <= ot_side.kind;
      rsp_saturated     <= ot_sat;
      rsp_zero_divisor  <= ot_side.zdiv;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_zdiv_contained: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divisor |->
         rsp_case_taken == CASE_CONTAINED && rsp_pair_distance == 0)
      else $error("zero divisor outside contained case or nonzero value");

   a_sat_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_case_taken == CASE_DISJOINT && rsp_pair_distance == VALUE_MAX)
      else $error("saturation outside disjoint case or wrong clamp");

   a_no_negative: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_pair_distance[31])
      else $error("negative distance");

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SQ_STAGES] |=> dv_vld_ff[0])
      else $error("valid lost between root and divider");

endmodule

`default_nettype wire
